>>> src/gnd_pkg.sv
// ----------------------------------------------------------------------------
// gnd_pkg: shared constants and helpers for the 2D gradient noise block
// Hash multiplier constants, their products with the reset seed, and the
// quarter-wave sine generator used to build the gradient table.
// ----------------------------------------------------------------------------
package gnd_pkg;

  localparam logic [31:0] HASH_K1     = 32'd3284157443;
  localparam logic [31:0] HASH_K2     = 32'd1911520717;
  localparam logic [31:0] HASH_K3     = 32'd2048419325;
  localparam logic [31:0] SEED_RESET  = 32'd100;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // seed products after reset
  localparam logic [63:0] M1_FULL = 64'(HASH_K1) * 64'(SEED_RESET);
  localparam logic [63:0] M2_FULL = 64'(HASH_K2) * 64'(SEED_RESET);
  localparam logic [63:0] M3_FULL = 64'(HASH_K3) * 64'(SEED_RESET);
  localparam logic [31:0] M1_RESET = M1_FULL[31:0];
  localparam logic [31:0] M2_RESET = M2_FULL[31:0];
  localparam logic [31:0] M3_RESET = M3_FULL[31:0];

  // Q14 sine of j/2^(abits-2) of a quarter turn, Taylor series in Q30.
  // Evaluated at elaboration only, to fill a constant table.
  function automatic logic [14:0] quarter_sine(input int unsigned j,
                                               input int unsigned abits);
    logic [63:0]        t;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    t    = (64'(j) * HALF_PI_Q30) >> (abits - 2);
    t2   = (t * t) >> 30;
    term = t;
    sum  = signed'(t);
    term = ((term * t2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * t2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * t2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * t2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * t2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd32768) >>> 16;
    if (sum > 64'sd16384) sum = 64'sd16384;
    return sum[14:0];
  endfunction

endpackage

>>> src/gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d: 2D gradient noise sample generator
// Turns one fixed-point coordinate pair into one saturated Q2.14 noise value.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with x_coord, y_coord (unsigned, FRAC_BITS
// fraction bits). Output channel: out_valid/out_stall with noise_value.
// A word moves at a clock edge where valid is high and stall is low.
// hash_seed_we/hash_seed_wdata load the hash seed; the seeded multipliers
// settle in the cycle after the write, so write it only while the pipe is empty.
// Each corner runs three hash multiply stages, a table lookup and a dot
// product, for all four corners in parallel; the weight blending and rounding
// stages follow.
// Throughput is one word per clock while out_stall does not hold the pipe; no
// path through a stage has more than one multiply.
// When out_stall holds a valid result the whole pipe freezes and in_stall
// rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset empties the pipe and sets the seed to 100.
// ----------------------------------------------------------------------------
module gradient_noise_2d #(
  parameter int ANGLE_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        x_coord,
  input  logic [31:0]        y_coord,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] noise_value,
  input  logic               hash_seed_we,
  input  logic [31:0]        hash_seed_wdata
);

  localparam int IW  = 33 - FRAC_BITS;
  localparam int OW  = FRAC_BITS + 2;
  localparam int DW  = FRAC_BITS + 17;
  localparam int PW  = DW + 19;
  localparam int NST = 9;

  // seed and seeded multipliers
  logic [31:0] seed, m1, m2, m3;
  logic [63:0] sp1, sp2, sp3;
  assign sp1 = 64'(gnd_pkg::HASH_K1) * 64'(seed);
  assign sp2 = 64'(gnd_pkg::HASH_K2) * 64'(seed);
  assign sp3 = 64'(gnd_pkg::HASH_K3) * 64'(seed);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= gnd_pkg::SEED_RESET;
      m1   <= gnd_pkg::M1_RESET;
      m2   <= gnd_pkg::M2_RESET;
      m3   <= gnd_pkg::M3_RESET;
    end else begin
      if (hash_seed_we) seed <= hash_seed_wdata;
      m1 <= sp1[31:0];
      m2 <= sp2[31:0];
      m3 <= sp3[31:0];
    end
  end

  // pipe advance
  logic           en;
  logic [NST-1:0] vld;
  assign en        = !(vld[NST-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // split coordinates into lattice index and offsets
  logic [IW-1:0]        ix0, ix1, iy0, iy1;
  logic [FRAC_BITS-1:0] fx, fy;
  logic signed [OW-1:0] dx0, dx1, dy0, dy1;
  assign ix0 = IW'(x_coord[31:FRAC_BITS]);
  assign iy0 = IW'(y_coord[31:FRAC_BITS]);
  assign ix1 = ix0 + IW'(1);
  assign iy1 = iy0 + IW'(1);
  assign fx  = x_coord[FRAC_BITS-1:0];
  assign fy  = y_coord[FRAC_BITS-1:0];
  assign dx0 = signed'(OW'(fx));
  assign dy0 = signed'(OW'(fy));
  assign dx1 = dx0 - signed'(OW'(1) << FRAC_BITS);
  assign dy1 = dy0 - signed'(OW'(1) << FRAC_BITS);

  // four corner lanes
  logic signed [DW-1:0] d00, d10, d01, d11;
  gnd_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c00 (
    .clk(clk), .en(en), .ix(ix0), .iy(iy0), .dx(dx0), .dy(dy0),
    .m1(m1), .m2(m2), .m3(m3), .dot(d00));
  gnd_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c10 (
    .clk(clk), .en(en), .ix(ix1), .iy(iy0), .dx(dx1), .dy(dy0),
    .m1(m1), .m2(m2), .m3(m3), .dot(d10));
  gnd_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c01 (
    .clk(clk), .en(en), .ix(ix0), .iy(iy1), .dx(dx0), .dy(dy1),
    .m1(m1), .m2(m2), .m3(m3), .dot(d01));
  gnd_corner #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_c11 (
    .clk(clk), .en(en), .ix(ix1), .iy(iy1), .dx(dx1), .dy(dy1),
    .m1(m1), .m2(m2), .m3(m3), .dot(d11));

  // fraction rescaled to Q16
  logic [15:0] sx, sy;
  if (FRAC_BITS >= 16) begin : g_sdown
    assign sx = fx[FRAC_BITS-1:FRAC_BITS-16];
    assign sy = fy[FRAC_BITS-1:FRAC_BITS-16];
  end else begin : g_sup
    assign sx = {fx, (16-FRAC_BITS)'(0)};
    assign sy = {fy, (16-FRAC_BITS)'(0)};
  end

  // smoothstep weights: s*s, then times (3 - 2s), then delay to the dots
  logic [15:0] sx1, sy1;
  logic [31:0] ssx1, ssy1;
  logic [16:0] wx2, wy2, wx3, wy3, wx4, wy4, wx5, wy5, wy6, wy7;
  logic [49:0] wpx, wpy;
  assign wpx = 50'(ssx1) * 50'(18'd196608 - {1'b0, sx1, 1'b0});
  assign wpy = 50'(ssy1) * 50'(18'd196608 - {1'b0, sy1, 1'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      sx1  <= sx;
      sy1  <= sy;
      ssx1 <= 32'(sx) * 32'(sx);
      ssy1 <= 32'(sy) * 32'(sy);
      wx2  <= wpx[48:32];
      wy2  <= wpy[48:32];
      wx3  <= wx2;  wy3 <= wy2;
      wx4  <= wx3;  wy4 <= wy3;
      wx5  <= wx4;  wy5 <= wy4;
    end
  end

  // blend along x: product stage, then add stage
  logic signed [PW-1:0] pt6, pb6, pv8;
  logic signed [DW-1:0] a06, b06, top7, bot7, top8;
  always_ff @(posedge clk) begin
    if (en) begin
      pt6  <= PW'(signed'((DW+1)'(d10) - (DW+1)'(d00)) * signed'({1'b0, wx5}));
      pb6  <= PW'(signed'((DW+1)'(d11) - (DW+1)'(d01)) * signed'({1'b0, wx5}));
      a06  <= d00;
      b06  <= d01;
      wy6  <= wy5;
      top7 <= a06 + DW'(pt6 >>> 16);
      bot7 <= b06 + DW'(pb6 >>> 16);
      wy7  <= wy6;
    end
  end

  // blend along y
  always_ff @(posedge clk) begin
    if (en) begin
      pv8  <= PW'(signed'((DW+1)'(bot7) - (DW+1)'(top7)) * signed'({1'b0, wy7}));
      top8 <= top7;
    end
  end

  // round to Q14 and saturate
  logic signed [DW-1:0] v8;
  logic signed [DW:0]   vr8;
  logic signed [17:0]   vq8;
  assign v8  = top8 + DW'(pv8 >>> 16);
  assign vr8 = (DW+1)'(v8) + signed'((DW+1)'(1) << (FRAC_BITS - 1));
  assign vq8 = 18'(vr8 >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      if (vq8 > 18'sd32767) begin
        noise_value <= 16'sh7fff;
      end else if (vq8 < -18'sd32768) begin
        noise_value <= -16'sh8000;
      end else begin
        noise_value <= vq8[15:0];
      end
    end
  end

endmodule

>>> src/gnd_corner.sv
// ----------------------------------------------------------------------------
// gnd_corner: one lattice corner
// Five-stage pipe: seeded hash over three multiply stages, gradient lookup
// from the sine table, then the dot product with the corner offset.
// ----------------------------------------------------------------------------
module gnd_corner #(
  parameter int ANGLE_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [32-FRAC_BITS:0]         ix,
  input  logic [32-FRAC_BITS:0]         iy,
  input  logic signed [FRAC_BITS+1:0]   dx,
  input  logic signed [FRAC_BITS+1:0]   dy,
  input  logic [31:0]                   m1,
  input  logic [31:0]                   m2,
  input  logic [31:0]                   m3,
  output logic signed [FRAC_BITS+16:0]  dot
);

  localparam int IW      = 33 - FRAC_BITS;
  localparam int OW      = FRAC_BITS + 2;
  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int QW      = ANGLE_BITS - 1;

  // quarter-wave table, constant logic
  logic [14:0] qtab [QUARTER+1];
  for (genvar j = 0; j <= QUARTER; j++) begin : g_tab
    assign qtab[j] = gnd_pkg::quarter_sine(j, ANGLE_BITS);
  end

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  logic [31:0]           a1;
  logic [31:0]           a2;
  logic [31:0]           b2;
  logic [IW-1:0]         iy1;
  logic [ANGLE_BITS-1:0] k3;
  logic signed [OW-1:0]  dx1, dx2, dx3, dx4;
  logic signed [OW-1:0]  dy1, dy2, dy3, dy4;
  logic signed [15:0]    gx4, gy4;
  logic [ANGLE_BITS-1:0] kidx [2];
  logic signed [15:0]    gval [2];
  logic [63:0]           prod1, prod2, prod3;

  assign prod1 = 64'(ix) * 64'(m1);
  assign prod2 = 64'(32'(iy1) ^ rot16(a1)) * 64'(m2);
  assign prod3 = 64'(a2 ^ rot16(b2)) * 64'(m3);

  // hash stages
  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= prod1[31:0];
      iy1 <= iy;
      a2  <= a1;
      b2  <= prod2[31:0];
      k3  <= prod3[31:32-ANGLE_BITS];
      dx1 <= dx;  dx2 <= dx1;  dx3 <= dx2;
      dy1 <= dy;  dy2 <= dy1;  dy3 <= dy2;
    end
  end

  // sine lookup: x gradient at k, y gradient a quarter turn later
  assign kidx[0] = k3;
  assign kidx[1] = k3 + ANGLE_BITS'(QUARTER);
  for (genvar g = 0; g < 2; g++) begin : g_sin
    logic [1:0]    q;
    logic [QW-1:0] r;
    logic [QW-1:0] ti;
    logic [14:0]   mag;
    always_comb begin
      q   = kidx[g][ANGLE_BITS-1:ANGLE_BITS-2];
      r   = QW'(kidx[g][ANGLE_BITS-3:0]);
      ti  = q[0] ? (QW'(QUARTER) - r) : r;
      mag = qtab[ti];
      gval[g] = q[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end
  end

  // gradient and dot product stages
  always_ff @(posedge clk) begin
    if (en) begin
      gx4 <= gval[0];
      gy4 <= gval[1];
      dx4 <= dx3;
      dy4 <= dy3;
      dot <= (FRAC_BITS+17)'(dx4 * gx4) + (FRAC_BITS+17)'(dy4 * gy4);
    end
  end

endmodule

>>> verif/tb_gradient_noise_2d.sv
// ----------------------------------------------------------------------------
// tb_gradient_noise_2d: self-checking testbench for the 2D gradient noise block
// Drives coordinate words through the valid/stall handshake, predicts each
// noise sample with an independent fixed-point model, and compares results in
// order. Runs through several hash seeds, with random idling on both sides in all but the last run.
// ----------------------------------------------------------------------------
module tb_gradient_noise_2d;

  localparam int ANGLE_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int TBL_SIZE   = 1 << ANGLE_BITS;
  localparam int QTR        = 1 << (ANGLE_BITS - 2);
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } coord_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        x_coord;
  logic [31:0]        y_coord;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] noise_value;
  logic               hash_seed_we;
  logic [31:0]        hash_seed_wdata;

  coord_t             coord_q[$];
  logic signed [15:0] noise_expected_q[$];
  logic [31:0]        seed_model;
  int                 sin_tbl[TBL_SIZE];
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 n_errors;
  int                 cycle_cnt;

  gradient_noise_2d #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_coord(x_coord), .y_coord(y_coord),
    .out_valid(out_valid), .out_stall(out_stall),
    .noise_value(noise_value),
    .hash_seed_we(hash_seed_we), .hash_seed_wdata(hash_seed_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q14 quarter-wave sine, Taylor series in Q30 with truncation
  function automatic longint qsin(input longint j);
    longint unsigned t, t2, term;
    longint sum;
    t = (longint'(j) * 64'd1686629713) >> (ANGLE_BITS - 2);
    t2 = (t * t) >> 30;
    term = t;
    sum = longint'(t);
    for (int n = 1; n <= 5; n++) begin
      term = (term * t2) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 32768) >>> 16;
    if (sum > 16384) sum = 16384;
    return sum;
  endfunction

  function automatic logic [31:0] corner_hash(input logic [31:0] ix, input logic [31:0] iy);
    logic [31:0] a, b;
    a = ix * (gnd_pkg::HASH_K1 * seed_model);
    b = iy ^ {a[15:0], a[31:16]};
    b = b * (gnd_pkg::HASH_K2 * seed_model);
    a = a ^ {b[15:0], b[31:16]};
    return a * (gnd_pkg::HASH_K3 * seed_model);
  endfunction

  function automatic longint grad_dot(input logic [31:0] ix, input logic [31:0] iy,
                                      input longint dx, input longint dy);
    int k;
    k = int'(corner_hash(ix, iy) >> (32 - ANGLE_BITS));
    return dx * sin_tbl[k] + dy * sin_tbl[(k + QTR) % TBL_SIZE];
  endfunction

  function automatic longint smooth_wt(input longint f);
    longint unsigned s;
    s = longint'(f);
    return longint'((s * s * (3 * 65536 - 2 * s)) >> 32);
  endfunction

  function automatic longint lerp_wt(input longint a0, input longint a1, input longint w);
    return a0 + ((a1 - a0) * w >>> 16);
  endfunction

  function automatic logic signed [15:0] noise_sample(input coord_t c);
    logic [31:0] ix, iy;
    longint fx, fy, wx, wy, top, bot, v;
    ix = c.x >> FRAC_BITS;
    iy = c.y >> FRAC_BITS;
    fx = c.x[FRAC_BITS-1:0];
    fy = c.y[FRAC_BITS-1:0];
    wx = smooth_wt(fx);
    wy = smooth_wt(fy);
    top = lerp_wt(grad_dot(ix, iy, fx, fy),
                  grad_dot(ix + 1, iy, fx - 65536, fy), wx);
    bot = lerp_wt(grad_dot(ix, iy + 1, fx, fy - 65536),
                  grad_dot(ix + 1, iy + 1, fx - 65536, fy - 65536), wx);
    v = (lerp_wt(top, bot, wy) + 32768) >>> FRAC_BITS;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // driver: next word goes out once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (coord_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        x_coord  <= coord_q[0].x;
        y_coord  <= coord_q[0].y;
        noise_expected_q.push_back(noise_sample(coord_q[0]));
        void'(coord_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && out_valid && !out_stall) begin
      if (noise_expected_q.size() == 0) begin
        $error("noise_value: unexpected word %0d", noise_value);
        n_errors <= n_errors + 1;
      end else begin
        if (noise_value !== noise_expected_q[0]) begin
          $error("noise_value: expected %0d actual %0d", noise_expected_q[0], noise_value);
          n_errors <= n_errors + 1;
        end
        void'(noise_expected_q.pop_front());
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_coord(input logic [31:0] x, input logic [31:0] y);
    coord_t c;
    c.x = x;
    c.y = y;
    coord_q.push_back(c);
  endtask

  // wait for the pipe to drain, then idle before the next phase
  task automatic drain();
    while (coord_q.size() > 0 || noise_expected_q.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_seed(input logic [31:0] seed);
    @(posedge clk);
    hash_seed_we    <= 1'b1;
    hash_seed_wdata <= seed;
    @(posedge clk);
    hash_seed_we <= 1'b0;
    seed_model = seed;
    repeat (2) @(posedge clk);
  endtask

  task automatic random_coords(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: add_coord($urandom, $urandom);
        1: add_coord($urandom_range(32'h0004_0000), $urandom_range(32'h0004_0000));
        2: add_coord({16'hFFFF, 16'($urandom)}, $urandom);
        default: add_coord({16'($urandom_range(3)), 16'($urandom)},
                           {16'($urandom), 16'hFFFF - 16'($urandom_range(7))});
      endcase
    end
  endtask

  initial begin
    for (int k = 0; k < TBL_SIZE; k++) begin
      int r, m;
      r = k % QTR;
      m = ((k / QTR) % 2 == 1) ? int'(qsin(QTR - r)) : int'(qsin(r));
      sin_tbl[k] = ((k / QTR) >= 2) ? -m : m;
    end
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    x_coord = '0;
    y_coord = '0;
    hash_seed_we = 1'b0;
    hash_seed_wdata = '0;
    seed_model = gnd_pkg::SEED_RESET;
    n_errors = 0;
    cycle_cnt = 0;
    send_idle_pct = 14;
    recv_idle_pct = 55;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, lattice points, top cell, half points
    add_coord(32'h0, 32'h0);
    add_coord(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_coord(32'hFFFF_FFFF, 32'h0);
    add_coord(32'h0, 32'hFFFF_FFFF);
    add_coord(32'h0000_8000, 32'h0000_8000);
    add_coord(32'h0001_0000, 32'h0002_0000);
    add_coord(32'hFFFF_8000, 32'hFFFF_8000);
    add_coord(32'hAAAA_AAAA, 32'h5555_5555);
    add_coord(32'h5555_5555, 32'hAAAA_AAAA);
    add_coord(32'h0000_FFFF, 32'h0000_0001);
    add_coord(32'h1234_4000, 32'h8765_C000);
    random_coords(300);
    drain();

    load_seed(32'h0);
    random_coords(100);
    drain();
    load_seed(32'hFFFF_FFFF);
    send_idle_pct = 55;
    recv_idle_pct = 14;
    random_coords(250);
    drain();
    load_seed($urandom);
    random_coords(200);
    drain();
    load_seed($urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_coords(300);
    drain();

    if (n_errors == 0 && noise_expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
